@@ src/bfl_pkg.sv @@
// Package for the band run-length fill block: item, command and register types,
// size constants and the result formatting function. No dependencies.
`default_nettype none

package bfl_pkg;

  localparam int unsigned MAX_MIN_RUN  = 64;
  localparam int unsigned MAX_CHANNELS = 4;
  localparam int unsigned PEND_DEPTH   = MAX_MIN_RUN - 1;
  localparam int unsigned RUN_W        = 7;
  localparam int unsigned SLOT_W       = 6;
  localparam int unsigned CMD_DEPTH    = 4;

  localparam logic [7:0]        CHAN_FORCED = 8'hFF;
  localparam logic [RUN_W-1:0]  RUN_MAX     = 7'd127;
  localparam logic [RUN_W-1:0]  MIN_RUN_CAP = RUN_W'(MAX_MIN_RUN);
  localparam logic [SLOT_W-1:0] SLOT_CAP    = SLOT_W'(PEND_DEPTH);
  localparam logic [2:0]        CHAN_CAP    = 3'(MAX_CHANNELS);

  // register indexes, byte address 4*index
  typedef enum logic [2:0] {
    REG_TRACE      = 3'd0,
    REG_HALF_WIDTH = 3'd1,
    REG_FILL_LONG  = 3'd2,
    REG_MIN_RUN    = 3'd3,
    REG_FILL_VALUE = 3'd4,
    REG_CHANNELS   = 3'd5
  } reg_e;
  localparam int unsigned NUM_REGS = 6;

  typedef logic [31:0] pix_t;   // {c3, c2, c1, c0}

  typedef struct packed {
    logic [7:0] chan0_in;
    logic [7:0] chan1_in;
    logic [7:0] chan2_in;
    logic [7:0] chan3_in;
    logic       line_end_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] chan0_out;
    logic [7:0] chan1_out;
    logic [7:0] chan2_out;
    logic [7:0] chan3_out;
    logic       line_end_out;
    logic       burst_last;
  } out_item_t;

  typedef struct packed {
    logic [7:0]       trace_level;
    logic [7:0]       band_half_width;
    logic             fill_long_runs;
    logic [RUN_W-1:0] min_run;
    logic [7:0]       fill_value;
    logic [2:0]       channel_count;
  } cfg_t;

  // store: write pix to the held-pixel slot.
  // otherwise: emit slot held pixels (flush_fill), then pix (pix_fill, pix_le).
  typedef struct packed {
    logic              store;
    logic [SLOT_W-1:0] slot;
    logic              flush_fill;
    pix_t              pix;
    logic              pix_fill;
    logic              pix_le;
  } cmd_t;

  function automatic out_item_t fmt_result(pix_t pix, logic fill, logic le, logic last,
                                           cfg_t cfg);
    logic [2:0] ch;
    out_item_t  r;
    if (cfg.channel_count == 3'd0) begin
      ch = 3'd1;
    end else if (cfg.channel_count > CHAN_CAP) begin
      ch = CHAN_CAP;
    end else begin
      ch = cfg.channel_count;
    end
    r.chan0_out    = fill ? cfg.fill_value : pix[7:0];
    r.chan1_out    = (ch > 3'd1) ? CHAN_FORCED : 8'd0;
    r.chan2_out    = (ch > 3'd2) ? pix[23:16] : 8'd0;
    r.chan3_out    = (ch > 3'd3) ? pix[31:24] : 8'd0;
    r.line_end_out = le;
    r.burst_last   = last;
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/bfl_front.sv @@
// Front end: band test and run tracking, one command per accepted item.
// Depends on bfl_pkg.
`default_nettype none

module bfl_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  bfl_pkg::in_item_t item_i,
  input  bfl_pkg::cfg_t   cfg_i,
  output bfl_pkg::cmd_t   cmd_o
);
  import bfl_pkg::*;

  logic             run_active_q, run_active_d;
  logic             run_decided_q, run_decided_d;
  logic [RUN_W-1:0] run_count_q, run_count_d;

  logic [RUN_W-1:0] mr, rc;
  logic [RUN_W:0]   rc_inc;
  logic [8:0]       lo_sum, hi_sum;
  logic             in_band, decide, is_long;
  pix_t             pix;

  assign pix = {item_i.chan3_in, item_i.chan2_in, item_i.chan1_in, item_i.chan0_in};
  assign mr  = (cfg_i.min_run > MIN_RUN_CAP) ? MIN_RUN_CAP : cfg_i.min_run;

  // c0 > tl - hw  <=>  c0 + hw > tl ;  c0 < tl + hw, no wrap in 9 bits
  assign lo_sum  = {1'b0, item_i.chan0_in} + {1'b0, cfg_i.band_half_width};
  assign hi_sum  = {1'b0, cfg_i.trace_level} + {1'b0, cfg_i.band_half_width};
  assign in_band = (lo_sum > {1'b0, cfg_i.trace_level}) &&
                   ({1'b0, item_i.chan0_in} < hi_sum);

  assign rc      = run_active_q ? run_count_q : '0;
  assign rc_inc  = {1'b0, rc} + (RUN_W+1)'(1);
  assign decide  = rc_inc >= {1'b0, mr};
  assign is_long = run_count_q >= mr;

  function automatic logic [SLOT_W-1:0] cap_slot(logic [RUN_W-1:0] v);
    return (v > {1'b0, SLOT_CAP}) ? SLOT_CAP : v[SLOT_W-1:0];
  endfunction

  always_comb begin
    run_active_d   = run_active_q;
    run_decided_d  = run_decided_q;
    run_count_d    = run_count_q;
    cmd_o.store      = 1'b0;
    cmd_o.slot       = '0;
    cmd_o.flush_fill = 1'b0;
    cmd_o.pix        = pix;
    cmd_o.pix_fill   = 1'b0;
    cmd_o.pix_le     = item_i.line_end_in;
    if (in_band && !item_i.line_end_in) begin
      cmd_o.pix_le = 1'b0;
      if (run_active_q && run_decided_q) begin
        cmd_o.pix_fill = cfg_i.fill_long_runs;
        if (run_count_q != RUN_MAX) begin
          run_count_d = run_count_q + RUN_W'(1);
        end
      end else begin
        run_active_d = 1'b1;
        run_count_d  = rc_inc[RUN_W-1:0];
        if (decide) begin
          cmd_o.slot       = cap_slot(rc);
          cmd_o.flush_fill = cfg_i.fill_long_runs;
          cmd_o.pix_fill   = cfg_i.fill_long_runs;
          run_decided_d    = 1'b1;
        end else begin
          cmd_o.store   = 1'b1;
          cmd_o.slot    = rc[SLOT_W-1:0];
          run_decided_d = 1'b0;
        end
      end
    end else begin
      if (run_active_q && !run_decided_q) begin
        cmd_o.slot       = cap_slot(run_count_q);
        cmd_o.flush_fill = is_long ? cfg_i.fill_long_runs : !cfg_i.fill_long_runs;
      end
      run_active_d  = 1'b0;
      run_decided_d = 1'b0;
      run_count_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_active_q  <= 1'b0;
      run_decided_q <= 1'b0;
      run_count_q   <= '0;
    end else if (accept_i) begin
      run_active_q  <= run_active_d;
      run_decided_q <= run_decided_d;
      run_count_q   <= run_count_d;
    end
  end

endmodule

`default_nettype wire

@@ src/bfl_cmd_fifo.sv @@
// Short command queue between front and back end.
// Depends on bfl_pkg.
`default_nettype none

module bfl_cmd_fifo #(
  parameter int unsigned Depth = bfl_pkg::CMD_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  bfl_pkg::cmd_t wdata_i,
  output logic          full_o,
  input  logic          rd_i,
  output bfl_pkg::cmd_t rdata_o,
  output logic          empty_o
);
  import bfl_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_wr, do_rd;

  assign full_o  = cnt_q == CntFull;
  assign empty_o = cnt_q == '0;
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= (wptr_q == PtrLast) ? '0 : wptr_q + PtrW'(1);
      end
      if (do_rd) begin
        rptr_q <= (rptr_q == PtrLast) ? '0 : rptr_q + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ src/bfl_back.sv @@
// Back end: held-pixel memory, flush sequencer and output register.
// Depends on bfl_pkg.
`default_nettype none

module bfl_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  bfl_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  input  bfl_pkg::cfg_t      cfg_i,
  output bfl_pkg::out_item_t result_o,
  output logic               empty_o,
  input  logic               pop_i
);
  import bfl_pkg::*;

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_READ = 4'b0010,
    B_SEND = 4'b0100,
    B_PIX  = 4'b1000
  } back_state_e;

  back_state_e       state_q, state_d;
  cmd_t              cur_q;
  logic [SLOT_W-1:0] pos_q, pos_d, pos_nx;
  pix_t              pend_mem [PEND_DEPTH];
  pix_t              rd_q;
  out_item_t         out_q, out_d;
  logic              out_valid_q, out_load, out_free;
  logic              take_cmd, mem_wr, mem_rd;

  assign out_free = !out_valid_q || pop_i;
  assign pos_nx   = pos_q + SLOT_W'(1);
  assign empty_o  = !out_valid_q;
  assign result_o = out_q;
  assign cmd_pop_o = take_cmd;

  always_comb begin
    state_d  = state_q;
    pos_d    = pos_q;
    take_cmd = 1'b0;
    mem_wr   = 1'b0;
    mem_rd   = 1'b0;
    out_load = 1'b0;
    out_d    = fmt_result(cur_q.pix, cur_q.pix_fill, cur_q.pix_le, 1'b1, cfg_i);
    unique case (state_q)
      B_IDLE: begin
        if (cmd_valid_i) begin
          take_cmd = 1'b1;
          pos_d    = '0;
          if (cmd_i.store) begin
            mem_wr = 1'b1;
          end else begin
            state_d = (cmd_i.slot == '0) ? B_PIX : B_READ;
          end
        end
      end
      B_READ: begin
        mem_rd  = 1'b1;
        state_d = B_SEND;
      end
      B_SEND: begin
        out_d = fmt_result(rd_q, cur_q.flush_fill, 1'b0, 1'b0, cfg_i);
        if (out_free) begin
          out_load = 1'b1;
          pos_d    = pos_nx;
          state_d  = (pos_nx == cur_q.slot) ? B_PIX : B_READ;
        end
      end
      B_PIX: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_wr) begin
      pend_mem[cmd_i.slot] <= cmd_i.pix;
    end
    if (mem_rd) begin
      rd_q <= pend_mem[pos_q];
    end
    if (take_cmd) begin
      cur_q <= cmd_i;
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ src/band_run_length_fill.sv @@
// Top level of the band run-length fill block: register file, front end,
// command queue and back end. Depends on bfl_pkg, bfl_front, bfl_cmd_fifo, bfl_back.
//
// Pixels enter through a queue-style port (push/full) and leave through another
// (empty/pop), every pixel exactly once and in order. A pixel whose first channel
// lies strictly inside (trace_level - band_half_width, trace_level +
// band_half_width) extends the current run, unless it is the last pixel of a
// line, which always ends the run and goes out unfilled. Run pixels are parked
// in a 63-entry pixel store until the run is judged long (length reaches min_run,
// capped at 64) or ends short; fill_long_runs picks which kind gets its first
// channel replaced by fill_value. With channel_count above one the second channel
// reads 255; channels at or beyond channel_count read zero. burst_last marks the
// final result caused by one input item; an item that only parks a pixel gives
// none. Rate: the front end takes one item per cycle while the four-entry command
// queue has room. The back end sets the sustained rate: a command that emits only
// its own pixel passes through the idle and pixel states, each parked pixel flushed
// with it adds a memory read, then an output register load, and parking a pixel
// is done in the idle state alone. It takes a new command only once the last is
// done. Results sit in an output register, so while one waits the back end can
// still park pixels and fetch the next parked one; it stalls only when its next
// result is ready to load.
// Registers (APB, byte address 4*i): 0 trace_level, 1 band_half_width,
// 2 fill_long_runs (reset 1), 3 min_run, 4 fill_value, 5 channel_count (reset 1).
// Write them only while the block is idle. The pixel store needs no clearing
// after reset: only slots written in the current run are ever read.
`default_nettype none

module band_run_length_fill #(
  parameter int unsigned CmdDepth = bfl_pkg::CMD_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // pixel input
  input  logic               push,
  output logic               full,
  input  bfl_pkg::in_item_t  in_item_i,
  // result output
  output logic               empty,
  input  logic               pop,
  output bfl_pkg::out_item_t result_o,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import bfl_pkg::*;

  cfg_t       cfg_q;
  logic       cfg_wr;
  logic [2:0] reg_idx;

  logic accept;
  cmd_t front_cmd, queue_cmd;
  logic q_full, q_empty, q_pop;

  // ---------------------------------------------------------------- registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trace_level     <= '0;
      cfg_q.band_half_width <= '0;
      cfg_q.fill_long_runs  <= 1'b1;
      cfg_q.min_run         <= '0;
      cfg_q.fill_value      <= '0;
      cfg_q.channel_count   <= 3'd1;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_TRACE:      cfg_q.trace_level     <= pwdata[7:0];
        REG_HALF_WIDTH: cfg_q.band_half_width <= pwdata[7:0];
        REG_FILL_LONG:  cfg_q.fill_long_runs  <= pwdata[0];
        REG_MIN_RUN:    cfg_q.min_run         <= pwdata[RUN_W-1:0];
        REG_FILL_VALUE: cfg_q.fill_value      <= pwdata[7:0];
        REG_CHANNELS:   cfg_q.channel_count   <= pwdata[2:0];
        default: ;  // beyond the register list: ignored
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TRACE:      prdata = {24'd0, cfg_q.trace_level};
      REG_HALF_WIDTH: prdata = {24'd0, cfg_q.band_half_width};
      REG_FILL_LONG:  prdata = {31'd0, cfg_q.fill_long_runs};
      REG_MIN_RUN:    prdata = {25'd0, cfg_q.min_run};
      REG_FILL_VALUE: prdata = {24'd0, cfg_q.fill_value};
      REG_CHANNELS:   prdata = {29'd0, cfg_q.channel_count};
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- front end
  // Every accepted item turns into exactly one command, so the queue's full
  // flag is the input back-pressure.
  assign full   = q_full;
  assign accept = push && !q_full;

  bfl_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_item_i),
    .cfg_i    (cfg_q),
    .cmd_o    (front_cmd)
  );

  // ---------------------------------------------------------------- queue
  bfl_cmd_fifo #(
    .Depth (CmdDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (accept),
    .wdata_i (front_cmd),
    .full_o  (q_full),
    .rd_i    (q_pop),
    .rdata_o (queue_cmd),
    .empty_o (q_empty)
  );

  // ---------------------------------------------------------------- back end
  // Park/flush commands are carried out in order, so a new run never
  // overwrites pixels that an older flush still has to read.
  bfl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!q_empty),
    .cmd_i       (queue_cmd),
    .cmd_pop_o   (q_pop),
    .cfg_i       (cfg_q),
    .result_o    (result_o),
    .empty_o     (empty),
    .pop_i       (pop)
  );

endmodule

`default_nettype wire

@@ src/bfl_checker.sv @@
// Port-level checks for band_run_length_fill, attached by bind.
// Depends on bfl_pkg.
`default_nettype none

module bfl_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               push,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input bfl_pkg::out_item_t result_o
);

  // waiting result holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(result_o)))
    else $error("result changed or vanished while waiting");

  // line end pixel is always emitted last for its input item
  a_le_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.line_end_out) |-> result_o.burst_last)
    else $error("line end result not marked as burst end");

  // input side only fills up through an accepted item
  a_full_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full && !$past(full)) |-> $past(push))
    else $error("full rose without an item pushed");

  // out of reset: nothing queued, input open
  a_reset: assert property (@(posedge clk_i)
    (rst_ni && !$past(rst_ni)) |-> (empty && !full))
    else $error("block not clear after reset");

endmodule

bind band_run_length_fill bfl_checker u_bfl_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .push     (push),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .result_o (result_o)
);

`default_nettype wire

@@ bench/band_run_length_fill_tb.sv @@
// Self-checking bench for band_run_length_fill: a directed table, then random pixel lines
// under several register settings, all results checked in order. Depends on bfl_pkg.
module band_run_length_fill_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bfl_pkg::*;

  // register settings applied in the directed table
  typedef enum logic [2:0] {SETUP_NONE, SETUP_MID, SETUP_WIDE, SETUP_TOP, SETUP_SHUT} setup_e;

  // one table row: optional setting, the pixel, and a hand-typed result where obvious
  typedef struct packed {
    setup_e    setup;
    in_item_t  px;
    logic      typed;
    out_item_t want;
  } vec_t;

  localparam int DIR_ROWS    = 21;
  localparam int PHASES      = 7;
  localparam int RAND_ITEMS  = 208;  // shared by the phases; about 230 items with the table
  localparam int SETTLE      = 40;   // back end may still be parking pixels
  localparam int HOLD_CYCLES = 400;

  localparam vec_t DIR_TAB [DIR_ROWS] = '{
    // reset settings: band (0,0) is empty, one channel, so each pixel passes alone
    '{SETUP_NONE, '{8'hAB, 8'h12, 8'h34, 8'h56, 1'b0}, 1'b1,
      '{8'hAB, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1}},
    '{SETUP_NONE, '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1}, 1'b1,
      '{8'hFF, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1}},
    '{SETUP_NONE, '{8'h00, 8'h00, 8'h00, 8'h00, 1'b0}, 1'b1,
      '{8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1}},
    // band (90,110), min run 3: parks two, decides on the third, passes the fourth,
    // both band edges end runs, line end inside the band flushes a short run
    '{SETUP_MID,  '{8'd95,  8'h01, 8'h02, 8'h03, 1'b0}, 1'b0, '0},
    '{SETUP_NONE, '{8'd96,  8'hA5, 8'h5A, 8'hC3, 1'b0}, 1'b0, '0},
    '{SETUP_NONE, '{8'd97,  8'h3C, 8'hF0, 8'h0F, 1'b0}, 1'b0, '0},
    '{SETUP_NONE, '{8'd105, 8'h00, 8'hFF, 8'h80, 1'b0}, 1'b0, '0},
    '{SETUP_NONE, '{8'd110, 8'h11, 8'h22, 8'h33, 1'b0}, 1'b0, '0},
    '{SETUP_NONE, '{8'd90,  8'h44, 8'h55, 8'h66, 1'b0}, 1'b0, '0},
    '{SETUP_NONE, '{8'd101, 8'h77, 8'h88, 8'h99, 1'b0}, 1'b0, '0},
    '{SETUP_NONE, '{8'd100, 8'hAA, 8'hBB, 8'hCC, 1'b1}, 1'b0, '0},
    // min run above its cap, fill short runs: a short run is filled when it ends
    '{SETUP_WIDE, '{8'd10,  8'h01, 8'h7F, 8'hFE, 1'b0}, 1'b0, '0},
    '{SETUP_NONE, '{8'd20,  8'h02, 8'hBF, 8'hFD, 1'b0}, 1'b0, '0},
    '{SETUP_NONE, '{8'd30,  8'h04, 8'hDF, 8'hFB, 1'b0}, 1'b0, '0},
    '{SETUP_NONE, '{8'd255, 8'h08, 8'hEF, 8'hF7, 1'b0}, 1'b0, '0},
    // min run zero: every run decided at its first pixel; channel count zero
    '{SETUP_TOP,  '{8'd0,   8'h10, 8'hF7, 8'hEF, 1'b0}, 1'b0, '0},
    '{SETUP_NONE, '{8'd200, 8'h20, 8'hFB, 8'hDF, 1'b0}, 1'b0, '0},
    '{SETUP_NONE, '{8'd255, 8'h40, 8'hFD, 8'hBF, 1'b0}, 1'b0, '0},
    '{SETUP_NONE, '{8'd1,   8'h80, 8'hFE, 8'h7F, 1'b1}, 1'b0, '0},
    // zero half width shuts the band; three channels
    '{SETUP_SHUT, '{8'h80, 8'h01, 8'hC3, 8'h7E, 1'b0}, 1'b1,
      '{8'h80, 8'hFF, 8'hC3, 8'h00, 1'b0, 1'b1}},
    '{SETUP_NONE, '{8'h7F, 8'h00, 8'h00, 8'hFF, 1'b1}, 1'b1,
      '{8'h7F, 8'hFF, 8'h00, 8'h00, 1'b1, 1'b1}}
  };

  // ---------------------------------------------------------------- DUT and its ports
  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        push    = 1'b0;
  logic        full;
  in_item_t    in_item = '0;
  logic        empty;
  logic        pop     = 1'b0;
  out_item_t   result_o;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [4:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  band_run_length_fill uut (
    .clk_i, .rst_ni, .push, .full, .in_item_i(in_item), .empty, .pop, .result_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------- fill predictor
  // Own copy of the registers and of the run tracker.
  cfg_t             cfg_now = '{8'd0, 8'd0, 1'b1, 7'd0, 8'd0, 3'd1};
  pix_t             park_buf [PEND_DEPTH];
  logic [RUN_W-1:0] park_len = '0;    // run length so far, saturating
  bit               run_open = 1'b0;
  bit               run_long = 1'b0;  // run has reached min run
  out_item_t        fresh [$];        // results of the latest pixel
  out_item_t        due_pixels [$];   // results still to come out, oldest first
  int               n_errs = 0;

  function automatic out_item_t shape_pixel(pix_t p, bit fill, bit le);
    int        ch;
    out_item_t r;
    ch = cfg_now.channel_count;
    if (ch == 0) ch = 1;
    if (ch > MAX_CHANNELS) ch = MAX_CHANNELS;
    r.chan0_out    = fill ? cfg_now.fill_value : p[7:0];
    r.chan1_out    = (ch > 1) ? 8'hFF : 8'h00;
    r.chan2_out    = (ch > 2) ? p[23:16] : 8'h00;
    r.chan3_out    = (ch > 3) ? p[31:24] : 8'h00;
    r.line_end_out = le;
    r.burst_last   = 1'b0;
    return r;
  endfunction

  function automatic void flush_parked(bit fill);
    int n;
    n = (park_len > PEND_DEPTH) ? PEND_DEPTH : park_len;
    for (int i = 0; i < n; i++) fresh.push_back(shape_pixel(park_buf[i], fill, 1'b0));
  endfunction

  // Advance the run tracker by one pixel; results land in fresh.
  function automatic void band_fill_step(in_item_t px);
    pix_t p;
    int   lo, hi, mr, c0;
    bit   in_band, fl, le;
    p       = {px.chan3_in, px.chan2_in, px.chan1_in, px.chan0_in};
    c0      = px.chan0_in;
    lo      = int'(cfg_now.trace_level) - int'(cfg_now.band_half_width);
    hi      = int'(cfg_now.trace_level) + int'(cfg_now.band_half_width);
    in_band = (c0 > lo) && (c0 < hi);
    mr      = (cfg_now.min_run > MAX_MIN_RUN) ? MAX_MIN_RUN : cfg_now.min_run;
    fl      = cfg_now.fill_long_runs;
    le      = px.line_end_in;
    fresh.delete();
    if (in_band && !le) begin
      if (run_open && run_long) begin
        fresh.push_back(shape_pixel(p, fl, 1'b0));
        if (park_len != RUN_MAX) park_len++;
      end else begin
        if (!run_open) begin
          run_open = 1'b1;
          run_long = 1'b0;
          park_len = '0;
        end
        if (int'(park_len) + 1 >= mr) begin
          flush_parked(fl);
          fresh.push_back(shape_pixel(p, fl, 1'b0));
          run_long = 1'b1;
          park_len++;
        end else begin
          if (park_len < PEND_DEPTH) park_buf[park_len[SLOT_W-1:0]] = p;
          park_len++;
        end
      end
    end else begin
      // run ends: an undecided run is judged on its final length
      if (run_open) begin
        if (!run_long) flush_parked((int'(park_len) >= mr) ? fl : !fl);
        run_open = 1'b0;
        run_long = 1'b0;
        park_len = '0;
      end
      fresh.push_back(shape_pixel(p, 1'b0, le));
    end
    if (fresh.size() > 0) fresh[fresh.size()-1].burst_last = 1'b1;
  endfunction

  // ---------------------------------------------------------------- result side
  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_errs++;
    end
  endfunction

  task automatic take_result(out_item_t got);
    out_item_t want;
    if (due_pixels.size() == 0) begin
      $error("result with nothing expected: %p", got);
      n_errs++;
    end else begin
      want = due_pixels.pop_front();
      check_field("chan0_out",    want.chan0_out,        got.chan0_out);
      check_field("chan1_out",    want.chan1_out,        got.chan1_out);
      check_field("chan2_out",    want.chan2_out,        got.chan2_out);
      check_field("chan3_out",    want.chan3_out,        got.chan3_out);
      check_field("line_end_out", 8'(want.line_end_out), 8'(got.line_end_out));
      check_field("burst_last",   8'(want.burst_last),   8'(got.burst_last));
    end
  endtask

  // Receiver: a pop pattern in one of three modes (always ready, mostly ready, mostly
  // stalled), redrawn at random by a tick counter, plus one long hold-off on request from the stimulus.
  int holds_asked = 0;
  int holds_done  = 0;
  int hold_left   = 0;
  int rx_tick     = 0;
  int rx_mode     = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) take_result(result_o);
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (holds_done != holds_asked) begin
        holds_done = holds_asked;
        hold_left  = HOLD_CYCLES;
        pop <= 1'b0;
      end else begin
        rx_tick++;
        if (rx_tick % 48 == 0) rx_mode = $urandom_range(0, 2);
        case (rx_mode)
          0:       pop <= 1'b1;
          1:       pop <= ($urandom_range(0, 3) != 0);
          default: pop <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- pixel side
  int burst_left = 0;
  bit steady     = 1'b0;   // no gaps while the receiver is held off

  // Offer one item until accepted, then book its results and maybe pause.
  task automatic send_pixel(in_item_t px, bit typed, out_item_t want);
    int gap;
    in_item <= px;
    push    <= 1'b1;
    do @(posedge clk_i); while (full);
    band_fill_step(px);
    if (typed) due_pixels.push_back(want);
    else foreach (fresh[i]) due_pixels.push_back(fresh[i]);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap        = steady ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic drain_results();
    push <= 1'b0;
    while (due_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------- register port
  function automatic logic [31:0] reg_val(cfg_t c, reg_e r);
    case (r)
      REG_TRACE:      return 32'(c.trace_level);
      REG_HALF_WIDTH: return 32'(c.band_half_width);
      REG_FILL_LONG:  return 32'(c.fill_long_runs);
      REG_MIN_RUN:    return 32'(c.min_run);
      REG_FILL_VALUE: return 32'(c.fill_value);
      default:        return 32'(c.channel_count);
    endcase
  endfunction

  // Setup then access; psel stays high so accesses can follow back to back.
  task automatic reg_access(input reg_e r, input logic wr, input logic [31:0] v,
                            output logic [31:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rd = prdata;
  endtask

  task automatic check_regs();
    logic [31:0] rd;
    reg_e        r;
    for (int i = 0; i < NUM_REGS; i++) begin
      r = reg_e'(i);
      reg_access(r, 1'b0, '0, rd);
      if (rd !== reg_val(cfg_now, r)) begin
        $error("register %s: expected %0h, got %0h", r.name(), reg_val(cfg_now, r), rd);
        n_errs++;
      end
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write all registers once the block has gone quiet, then read them back.
  task automatic load_setup(cfg_t c);
    logic [31:0] rd;
    drain_results();
    for (int i = 0; i < NUM_REGS; i++) reg_access(reg_e'(i), 1'b1, reg_val(c, reg_e'(i)), rd);
    cfg_now = c;
    check_regs();
  endtask

  function automatic cfg_t setup_cfg(setup_e s);
    case (s)
      SETUP_MID:  return '{8'd100, 8'd10,  1'b1, 7'd3,   8'hEE, 3'd4};
      SETUP_WIDE: return '{8'd0,   8'd255, 1'b0, 7'd127, 8'h11, 3'd2};
      SETUP_TOP:  return '{8'd255, 8'd255, 1'b1, 7'd0,   8'hC4, 3'd0};
      default:    return '{8'd128, 8'd0,   1'b1, 7'd5,   8'h5A, 3'd3};
    endcase
  endfunction

  // Random phases: first the top extremes, then all zero but a channel count of one,
  // then random settings with min run mostly small so that runs get decided often.
  function automatic cfg_t phase_cfg(int ph);
    cfg_t c;
    case (ph)
      0: c = '{8'd255, 8'd255, 1'b1, 7'd64, 8'hFF, 3'd4};
      1: c = '{8'd0,   8'd0,   1'b0, 7'd0,  8'h00, 3'd1};
      default: begin
        c.trace_level     = 8'($urandom);
        c.band_half_width = 8'($urandom_range(1, 80));
        c.fill_long_runs  = 1'($urandom);
        c.min_run         = ($urandom_range(0, 5) == 0) ? 7'($urandom_range(64, 127))
                                                        : 7'($urandom_range(0, 6));
        c.fill_value      = 8'($urandom);
        c.channel_count   = 3'($urandom_range(0, 7));
      end
    endcase
    return c;
  endfunction

  // First channel inside the band, edges now and then; anything if the band is shut.
  function automatic logic [7:0] band_c0();
    int lo, hi;
    lo = int'(cfg_now.trace_level) - int'(cfg_now.band_half_width) + 1;
    hi = int'(cfg_now.trace_level) + int'(cfg_now.band_half_width) - 1;
    if (lo < 0) lo = 0;
    if (hi > 255) hi = 255;
    if (lo > hi) return 8'($urandom);
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 1) ? lo : hi);
    return 8'($urandom_range(hi, lo));
  endfunction

  // First channel outside the band; 0 when the band covers every value.
  function automatic bit clear_c0(output logic [7:0] c0);
    int below, above;
    bit low_side;
    below = int'(cfg_now.trace_level) - int'(cfg_now.band_half_width);
    above = int'(cfg_now.trace_level) + int'(cfg_now.band_half_width);
    c0    = '0;
    if (below < 0 && above > 255) return 1'b0;
    low_side = (above > 255) || (below >= 0 && $urandom_range(0, 1));
    if (low_side) c0 = 8'(($urandom_range(0, 2) == 0) ? below : $urandom_range(below, 0));
    else          c0 = 8'(($urandom_range(0, 2) == 0) ? above : $urandom_range(255, above));
    return 1'b1;
  endfunction

  // Mostly runs around min run closed by an out-of-band pixel or a line end;
  // a fifth of the time a fully random pixel. Reports how many items went out.
  task automatic feed_random(int n, output int sent);
    int         len, mr;
    in_item_t   px;
    logic [7:0] c0;
    sent = 0;
    while (sent < n) begin
      px = in_item_t'({$urandom, 1'b0});
      if ($urandom_range(0, 9) < 2) begin
        px.line_end_in = ($urandom_range(0, 3) == 0);
        send_pixel(px, 1'b0, '0);
        sent++;
      end else begin
        mr = (cfg_now.min_run > MAX_MIN_RUN) ? MAX_MIN_RUN : cfg_now.min_run;
        case ($urandom_range(0, 3))
          0:       len = (mr > 0) ? mr - 1 : 0;
          1:       len = mr;
          2:       len = mr + $urandom_range(1, 3);
          default: len = $urandom_range(0, 8);
        endcase
        for (int i = 0; i < len; i++) begin
          px          = in_item_t'({$urandom, 1'b0});
          px.chan0_in = band_c0();
          send_pixel(px, 1'b0, '0);
          sent++;
        end
        px = in_item_t'({$urandom, 1'b0});
        if ($urandom_range(0, 1) && clear_c0(c0)) px.chan0_in = c0;
        else px.line_end_in = 1'b1;
        send_pixel(px, 1'b0, '0);
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    in_item_t last_px;
    int       budget, sent;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_regs();   // reset values

    for (int row = 0; row < DIR_ROWS; row++) begin
      if (DIR_TAB[row].setup != SETUP_NONE) load_setup(setup_cfg(DIR_TAB[row].setup));
      send_pixel(DIR_TAB[row].px, DIR_TAB[row].typed, DIR_TAB[row].want);
    end

    // Runs stay open across setting changes, so a run may be judged under new values.
    // Long runs overshoot a phase's share; later phases get less.
    budget = RAND_ITEMS;
    for (int ph = 0; ph < PHASES; ph++) begin
      load_setup(phase_cfg(ph));
      if (ph == 2) begin
        // receiver holds off while items keep coming, so full must rise
        holds_asked++;
        steady = 1'b1;
      end
      feed_random(budget / (PHASES - ph), sent);
      budget -= sent;
      steady = 1'b0;
    end

    // a line end flushes whatever run is still parked
    last_px             = in_item_t'({$urandom, 1'b0});
    last_px.line_end_in = 1'b1;
    send_pixel(last_px, 1'b0, '0);
    drain_results();

    if (n_errs == 0 && due_pixels.size() == 0) begin
      $display("band_run_length_fill verification clean");
    end else begin
      $display("band_run_length_fill verification failed");
    end
    $finish;
  end

  // hard limit, far beyond the slowest legal run
  initial begin
    #2ms;
    $display("band_run_length_fill verification failed");
    $finish;
  end

endmodule
